### design/hdts_pkg.sv
// ----------------------------------------------------------------------------
// hdts_pkg: shared types, constants and helpers of the date header parser
// Beat types of both channels, slot layout of the captured bytes, month
// names and the atoi-style field decode.
// ----------------------------------------------------------------------------
package hdts_pkg;

	// beat types
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic signed [39:0] seconds;
		logic               month_unmatched;
	} out_beat_t;

	// captured bytes, indexed by slot
	localparam int SLOT_COUNT = 15;
	typedef logic [SLOT_COUNT-1:0][7:0] slot_bytes_t;
	typedef logic [3:0] slot_t;
	localparam slot_t NO_SLOT = 4'd15;

	// decoded fields of one date string
	typedef struct packed {
		logic signed [7:0]  day;
		logic signed [14:0] year;
		logic signed [7:0]  hour;
		logic signed [7:0]  minute;
		logic signed [7:0]  second;
		logic [3:0]         month;
		logic               unmatched;
	} fields_t;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// time constants
	localparam logic signed [39:0] YEAR_SECONDS  = 40'sd31556926;
	localparam logic signed [39:0] MONTH_SECONDS = 40'sd2629743;
	localparam logic signed [39:0] DAY_SECONDS   = 40'sd86400;
	localparam logic signed [39:0] HOUR_SECONDS  = 40'sd3600;
	localparam logic signed [39:0] MIN_SECONDS   = 40'sd60;
	localparam logic signed [15:0] EPOCH_YEAR    = 16'sd1970;

	localparam logic [3:0] MONTH_COUNT = 4'd12;
	localparam logic [11:0][23:0] MONTH_NAMES = {
		"Dec", "Nov", "Oct", "Sep", "Aug", "Jul",
		"Jun", "May", "Apr", "Mar", "Feb", "Jan"
	};

	// slot of each byte position, NO_SLOT where the byte is dropped
	function automatic slot_t slot_of_pos(input logic [4:0] pos);
		slot_t s;
		case (pos)
			5'd5:  s = 4'd0;
			5'd6:  s = 4'd1;
			5'd8:  s = 4'd2;
			5'd9:  s = 4'd3;
			5'd10: s = 4'd4;
			5'd12: s = 4'd5;
			5'd13: s = 4'd6;
			5'd14: s = 4'd7;
			5'd15: s = 4'd8;
			5'd17: s = 4'd9;
			5'd18: s = 4'd10;
			5'd20: s = 4'd11;
			5'd21: s = 4'd12;
			5'd23: s = 4'd13;
			5'd24: s = 4'd14;
			default: s = NO_SLOT;
		endcase
		return s;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// atoi over the first n bytes of b (b[0] first), n up to 4
	function automatic logic signed [15:0] atoi_field(input logic [3:0][7:0] b,
			input logic [2:0] n);
		logic        skip;
		logic        done;
		logic        neg;
		logic [15:0] val;
		logic [7:0]  c;
		skip = 1'b1;
		done = 1'b0;
		neg  = 1'b0;
		val  = '0;
		for (int i = 0; i < 4; i++) begin
			c = b[i];
			if (3'(i) < n && !done) begin
				if (skip && is_blank(c)) begin
					skip = 1'b1;
				end else if (skip && (c == CH_PLUS || c == CH_MINUS)) begin
					neg  = (c == CH_MINUS);
					skip = 1'b0;
				end else begin
					skip = 1'b0;
					if (c >= CH_0 && c <= CH_9) begin
						val = 16'(val * 16'd10) + {8'd0, 8'(c - CH_0)};
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		return neg ? $signed(16'(-val)) : $signed(val);
	endfunction

endpackage

### design/http_date_to_seconds_core.sv
// ----------------------------------------------------------------------------
// http_date_to_seconds_core: streaming date header to epoch seconds
// Bytes of a string such as "Mon, 01 Jan 1970 00:00:00 GMT" come in one
// beat each; the last beat yields the approximate seconds since 1970.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel: one byte per beat, item.last marks the final byte.
//    Bytes at the day, month, year and time positions are kept; the rest
//    are dropped. Every beat that is not last produces nothing.
//  - result channel: one beat per string, seconds (40-bit two's complement)
//    and month_unmatched (month name matched none, counted as 12).
//  - throughput: one byte per cycle while item_ready is high, also across
//    string boundaries; a new string may start the cycle after a last byte.
//  - pipeline: the decode register loads on the edge that takes the last
//    byte, then the product register, then the sum in the output register.
//  - stall: when result_ready is low the three stages fill up; item_ready
//    falls only when the decode stage holds a string that cannot move on.
//  - reset: position counter and kept bytes clear, all stages empty; the
//    counter and kept bytes also clear after every last byte.
// ----------------------------------------------------------------------------
module http_date_to_seconds_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  hdts_pkg::in_beat_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output hdts_pkg::out_beat_t  result
);

	logic [4:0]            pos_q;
	hdts_pkg::slot_bytes_t captured_q;
	hdts_pkg::slot_bytes_t snap_w;
	hdts_pkg::slot_t       slot_w;
	hdts_pkg::fields_t     fields_w;
	logic                  item_acc;

	logic                  v_s1;
	hdts_pkg::fields_t     fields_s1;
	logic                  v_s2;
	logic signed [39:0]    yr_term_s2;
	logic signed [39:0]    mon_term_s2;
	logic signed [39:0]    day_term_s2;
	logic signed [39:0]    hr_term_s2;
	logic signed [39:0]    min_term_s2;
	logic signed [39:0]    sec_term_s2;
	logic                  unmatched_s2;
	logic                  out_v_q;
	hdts_pkg::out_beat_t   out_q;

	logic                  out_free;
	logic                  s2_free;
	logic                  s1_free;
	logic signed [15:0]    year_off;

	// stage flow control
	assign out_free   = !out_v_q || result_ready;
	assign s2_free    = !v_s2 || out_free;
	assign s1_free    = !v_s1 || s2_free;
	assign item_ready = s1_free;
	assign item_acc   = item_valid && item_ready;

	// byte capture, current byte merged for the decode
	assign slot_w = hdts_pkg::slot_of_pos(pos_q);

	always_comb begin
		snap_w = captured_q;
		if (slot_w != hdts_pkg::NO_SLOT) begin
			snap_w[slot_w] = item.character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			captured_q <= '0;
		end else if (item_acc) begin
			if (item.last) begin
				pos_q      <= '0;
				captured_q <= '0;
			end else begin
				captured_q <= snap_w;
				if (pos_q != 5'd31) begin
					pos_q <= pos_q + 5'd1;
				end
			end
		end
	end

	hdts_decode u_decode (
		.bytes  (snap_w),
		.fields (fields_w)
	);

	// stage 1: decoded fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= item_acc && item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_acc && item.last) begin
			fields_s1 <= fields_w;
		end
	end

	// stage 2: constant products
	assign year_off = {fields_s1.year[14], fields_s1.year} - hdts_pkg::EPOCH_YEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			yr_term_s2  <= 40'({{24{year_off[15]}}, year_off} * hdts_pkg::YEAR_SECONDS);
			mon_term_s2 <= 40'($signed({36'd0, fields_s1.month}) * hdts_pkg::MONTH_SECONDS);
			day_term_s2 <= 40'({{32{fields_s1.day[7]}}, fields_s1.day}
				* hdts_pkg::DAY_SECONDS);
			hr_term_s2  <= 40'({{32{fields_s1.hour[7]}}, fields_s1.hour}
				* hdts_pkg::HOUR_SECONDS);
			min_term_s2 <= 40'({{32{fields_s1.minute[7]}}, fields_s1.minute}
				* hdts_pkg::MIN_SECONDS);
			sec_term_s2 <= {{32{fields_s1.second[7]}}, fields_s1.second};
			unmatched_s2 <= fields_s1.unmatched;
		end
	end

	// output register: sum of terms, less one day
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			out_q.seconds <= yr_term_s2 + mon_term_s2 + day_term_s2 + hr_term_s2
				+ min_term_s2 + sec_term_s2 - hdts_pkg::DAY_SECONDS;
			out_q.month_unmatched <= unmatched_s2;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	// checks
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.last |=> pos_q == 5'd0)
		else $error("position not cleared after last byte");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && !item.last && pos_q != 5'd31 |=> pos_q == $past(pos_q) + 5'd1)
		else $error("position did not advance");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> item_ready)
		else $error("input stalled with empty decode stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_free |=> v_s2 && $stable(yr_term_s2))
		else $error("product stage lost data under stall");

endmodule

### design/hdts_decode.sv
// ----------------------------------------------------------------------------
// hdts_decode: field decode of one captured date string
// Turns the fifteen kept bytes into day, year, hour, minute, second and
// month index, atoi style for the numbers and exact match for the month.
// ----------------------------------------------------------------------------
module hdts_decode (
	input  hdts_pkg::slot_bytes_t bytes,
	output hdts_pkg::fields_t     fields
);

	logic signed [15:0] day_w;
	logic signed [15:0] year_w;
	logic signed [15:0] hour_w;
	logic signed [15:0] min_w;
	logic signed [15:0] sec_w;
	logic [3:0]         month_w;
	logic [23:0]        name_w;

	// numeric fields
	assign day_w  = hdts_pkg::atoi_field({16'h0, bytes[1], bytes[0]}, 3'd2);
	assign year_w = hdts_pkg::atoi_field({bytes[8], bytes[7], bytes[6], bytes[5]}, 3'd4);
	assign hour_w = hdts_pkg::atoi_field({16'h0, bytes[10], bytes[9]}, 3'd2);
	assign min_w  = hdts_pkg::atoi_field({16'h0, bytes[12], bytes[11]}, 3'd2);
	assign sec_w  = hdts_pkg::atoi_field({16'h0, bytes[14], bytes[13]}, 3'd2);

	// month match, first name in calendar order wins
	assign name_w = {bytes[2], bytes[3], bytes[4]};

	always_comb begin
		month_w = hdts_pkg::MONTH_COUNT;
		for (int m = 11; m >= 0; m--) begin
			if (name_w == hdts_pkg::MONTH_NAMES[m]) begin
				month_w = 4'(m);
			end
		end
	end

	// pack results
	always_comb begin
		fields.day       = day_w[7:0];
		fields.year      = year_w[14:0];
		fields.hour      = hour_w[7:0];
		fields.minute    = min_w[7:0];
		fields.second    = sec_w[7:0];
		fields.month     = month_w;
		fields.unmatched = (month_w == hdts_pkg::MONTH_COUNT);
	end

endmodule

### tb/http_date_to_seconds_core_tb.sv
// ----------------------------------------------------------------------------
// http_date_to_seconds_core_tb: self-checking bench of the date header parser
// Streams date strings byte by byte into the core, predicts the seconds and
// the month flag of every string in the bench itself, and compares each
// result beat in order. Directed strings hit the field extremes, signs,
// blanks, bad month names and long strings; the rest are random strings,
// mostly well formed. Sender bursts, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module http_date_to_seconds_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 7;
	localparam int STUCK_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 8;
	localparam int BYTE_TARGET   = 1000;
	localparam int STRING_TARGET = 30;
	localparam int DATE_LEN      = 29;
	localparam int FRAME_LEN     = 48;
	localparam int KEPT_COUNT    = 15;
	localparam int NOT_KEPT      = -1;
	localparam int MONTHS        = 12;
	localparam logic [4:0] LAST_POSITION = 5'd31;

	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_TAB   = 8'h09;
	localparam logic [7:0] ASCII_CR    = 8'h0D;

	localparam longint SECONDS_PER_YEAR   = 31556926;
	localparam longint SECONDS_PER_MONTH  = 2629743;
	localparam longint SECONDS_PER_DAY    = 86400;
	localparam longint SECONDS_PER_HOUR   = 3600;
	localparam longint SECONDS_PER_MINUTE = 60;
	localparam longint BASE_YEAR          = 1970;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_RHYTHM
	} ready_mode_e;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	hdts_pkg::in_beat_t  item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	hdts_pkg::out_beat_t result;

	http_date_to_seconds_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// clock
	always #HALF_PERIOD clk = ~clk;

	// parser state mirrored in the bench
	logic [4:0]          position = '0;
	logic [7:0]          kept [KEPT_COUNT];
	hdts_pkg::out_beat_t seconds_due [$];
	hdts_pkg::in_beat_t  byte_stream [$];
	hdts_pkg::out_beat_t oldest_due;
	logic [7:0]          frame [FRAME_LEN];
	int                  bytes_total;
	int                  bytes_taken;
	int                  failures;

	// which kept byte a string position lands in
	function automatic int keep_index(input logic [4:0] p);
		case (p)
			5'd5, 5'd6:                   return int'(p) - 5;
			5'd8, 5'd9, 5'd10:            return int'(p) - 6;
			5'd12, 5'd13, 5'd14, 5'd15:   return int'(p) - 7;
			5'd17, 5'd18:                 return int'(p) - 8;
			5'd20, 5'd21:                 return int'(p) - 9;
			5'd23, 5'd24:                 return int'(p) - 10;
			default:                      return NOT_KEPT;
		endcase
	endfunction

	function automatic logic [23:0] month_name(input int m);
		case (m)
			0:       return "Jan";
			1:       return "Feb";
			2:       return "Mar";
			3:       return "Apr";
			4:       return "May";
			5:       return "Jun";
			6:       return "Jul";
			7:       return "Aug";
			8:       return "Sep";
			9:       return "Oct";
			10:      return "Nov";
			default: return "Dec";
		endcase
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == ASCII_SPACE || (c >= ASCII_TAB && c <= ASCII_CR);
	endfunction

	// atoi over n kept bytes starting at first
	function automatic longint field_value(input int first, input int n);
		int     i;
		bit     negative;
		longint v;
		i = 0;
		negative = 1'b0;
		v = 0;
		while (i < n && is_space(kept[first+i]))
			i++;
		if (i < n && (kept[first+i] == ASCII_PLUS || kept[first+i] == ASCII_MINUS)) begin
			negative = kept[first+i] == ASCII_MINUS;
			i++;
		end
		while (i < n && kept[first+i] >= ASCII_ZERO && kept[first+i] <= ASCII_NINE) begin
			v = v * 10 + longint'(kept[first+i] - ASCII_ZERO);
			i++;
		end
		return negative ? -v : v;
	endfunction

	// take one accepted byte; on the last one, queue the expected seconds
	task automatic parse_byte(input hdts_pkg::in_beat_t b);
		int                  k;
		int                  month;
		longint              total;
		hdts_pkg::out_beat_t r;
		k = keep_index(position);
		if (k != NOT_KEPT)
			kept[k] = b.character;
		if (!b.last) begin
			if (position < LAST_POSITION)
				position++;
		end else begin
			month = MONTHS;
			for (int m = 0; m < MONTHS; m++)
				if (month == MONTHS && {kept[2], kept[3], kept[4]} == month_name(m))
					month = m;
			total = (field_value(5, 4) - BASE_YEAR) * SECONDS_PER_YEAR
				+ longint'(month) * SECONDS_PER_MONTH
				+ field_value(0, 2) * SECONDS_PER_DAY
				+ field_value(9, 2) * SECONDS_PER_HOUR
				+ field_value(11, 2) * SECONDS_PER_MINUTE
				+ field_value(13, 2)
				- SECONDS_PER_DAY;
			r.seconds = total[39:0];
			r.month_unmatched = month == MONTHS;
			seconds_due.push_back(r);
			position = '0;
			for (int j = 0; j < KEPT_COUNT; j++)
				kept[j] = '0;
		end
	endtask

	// stimulus helpers
	function automatic logic [7:0] any_digit();
		return ASCII_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] any_sign();
		return $urandom_range(1) ? ASCII_PLUS : ASCII_MINUS;
	endfunction

	function automatic logic [7:0] any_blank();
		return ($urandom_range(5) == 0) ? ASCII_SPACE : ASCII_TAB + 8'($urandom_range(4));
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(5))
			0:       return any_digit();
			1:       return any_blank();
			2:       return any_sign();
			3:       return 8'h00;
			4:       return 8'($urandom_range(255));
			default: return 8'h61 + 8'($urandom_range(25));
		endcase
	endfunction

	task automatic queue_text(input string t);
		hdts_pkg::in_beat_t b;
		for (int i = 0; i < t.len(); i++) begin
			b.character = t[i];
			b.last = i == t.len() - 1;
			byte_stream.push_back(b);
		end
	endtask

	// numeric field: mostly digits, sometimes signs, blanks or junk
	task automatic fill_number(input int first, input int n);
		int mode;
		mode = $urandom_range(9);
		for (int j = 0; j < n; j++) begin
			if (mode <= 5)
				frame[first+j] = any_digit();
			else if (mode == 6)
				frame[first+j] = (j == 0) ? any_sign() : any_digit();
			else if (mode == 7)
				frame[first+j] = (j == 0) ? any_blank() :
					(j == 1 && $urandom_range(1)) ? any_sign() : any_digit();
			else
				frame[first+j] = any_char();
		end
	endtask

	task automatic queue_random_date();
		string              shape;
		int                 len;
		int                 pick;
		logic [23:0]        name;
		hdts_pkg::in_beat_t b;
		shape = "Mon, 01 Jan 1970 00:00:00 GMT";
		pick = $urandom_range(99);
		if (pick < 70)
			len = DATE_LEN;
		else if (pick < 85)
			len = $urandom_range(DATE_LEN - 1, 1);
		else
			len = $urandom_range(FRAME_LEN, DATE_LEN + 1);
		// separators and padding, now and then corrupted
		for (int p = 0; p < FRAME_LEN; p++)
			frame[p] = (p < DATE_LEN && $urandom_range(9) != 0) ? shape[p] :
				8'($urandom_range(255));
		fill_number(5, 2);
		fill_number(12, 4);
		fill_number(17, 2);
		fill_number(20, 2);
		fill_number(23, 2);
		// month name: mostly valid, else lower case, near miss or junk
		pick = $urandom_range(99);
		name = month_name($urandom_range(MONTHS - 1));
		if (pick >= 90)
			name = {any_char(), any_char(), any_char()};
		else if (pick >= 85)
			name[8*$urandom_range(2) +: 8] = any_char();
		else if (pick >= 80)
			name = name | 24'h200000;
		{frame[8], frame[9], frame[10]} = name;
		for (int p = 0; p < len; p++) begin
			b.character = frame[p];
			b.last = p == len - 1;
			byte_stream.push_back(b);
		end
	endtask

	// sender: bursts of beats with random gaps
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (item_valid && item_ready) begin
				parse_byte(item);
				bytes_taken++;
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (byte_stream.size() > 0) begin
					item <= byte_stream.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(60, 1);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: changing stall modes, plus one long hold-off to back up the core
	ready_mode_e ready_mode;
	int          mode_left;
	int          hold_left;
	bit          hold_done;
	int          results_taken;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_mode = READY_ALWAYS;
			mode_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
			results_taken = 0;
		end else begin
			if (result_valid && result_ready)
				results_taken++;
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!hold_done && results_taken == HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = ready_mode_e'($urandom_range(READY_RHYTHM));
					mode_left = $urandom_range(80, 20);
				end else begin
					mode_left--;
				end
				case (ready_mode)
					READY_ALWAYS: result_ready <= 1'b1;
					READY_COIN:   result_ready <= 1'($urandom_range(1));
					READY_SPARSE: result_ready <= $urandom_range(3) == 0;
					default:      result_ready <= (mode_left % 5) < 2;
				endcase
			end
		end
	end

	// result check against the oldest pending date
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (seconds_due.size() == 0) begin
				$error("result beat with no date pending: seconds=%0d month_unmatched=%0b",
					result.seconds, result.month_unmatched);
				failures++;
			end else begin
				oldest_due = seconds_due.pop_front();
				if (result.seconds !== oldest_due.seconds) begin
					$error("seconds: expected %0d, got %0d",
						oldest_due.seconds, result.seconds);
					failures++;
				end
				if (result.month_unmatched !== oldest_due.month_unmatched) begin
					$error("month_unmatched: expected %0b, got %0b",
						oldest_due.month_unmatched, result.month_unmatched);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int strings;
		for (int j = 0; j < KEPT_COUNT; j++)
			kept[j] = '0;
		bytes_taken = 0;
		failures = 0;
		// epoch, largest fields, smallest fields with a bad month
		queue_text("Mon, 01 Jan 1970 00:00:00 GMT");
		queue_text("Fri, 99 Dec 9999 99:99:99 GMT");
		queue_text("Sun, -9 Xyz -999 -9:-9:-9 GMT");
		// lower-case month, blanks before numbers, double sign, empty field
		queue_text("Tue, +5 jan  +12 \t7:--:  GMT");
		// one-byte string: every field reads as zero
		queue_text("Q");
		// long string runs the position counter into saturation
		queue_text("Wed, 15 Mar 2023 12:34:56 GMT plus trailing text here");
		strings = 6;
		while (byte_stream.size() < BYTE_TARGET || strings < STRING_TARGET) begin
			queue_random_date();
			strings++;
		end
		bytes_total = byte_stream.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < bytes_total)
			@(posedge clk);
		while (seconds_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### http_date_to_seconds_core.f
design/hdts_pkg.sv
design/hdts_decode.sv
design/http_date_to_seconds_core.sv
tb/http_date_to_seconds_core_tb.sv
